FILE: src/ale_pkg.sv
// Shared types and constants of the array list engine.
// No dependencies; used by array_list_engine.
package ale_pkg;

   localparam int DEPTH  = 8;
   localparam int DATA_W = 32;
   localparam int IDX_W  = 3;
   localparam int CNT_W  = 4;
   localparam int ROW_W  = DEPTH * DATA_W;

   typedef enum logic [2:0] {
      OP_CLEAR    = 3'd0,
      OP_PUSH     = 3'd1,
      OP_INSERT   = 3'd2,
      OP_POP_HEAD = 3'd3,
      OP_POP_TAIL = 3'd4,
      OP_POP_AT   = 3'd5,
      OP_READ_AT  = 3'd6,
      OP_FIND     = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_BADIDX   = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

endpackage

FILE: src/ale_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies.
module ale_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/array_list_engine.sv
// Array list engine top level: ordered list of signed 32-bit values in one RAM row.
// Depends on ale_pkg and ale_ram.
//
// Usage:
//   Request channel (req_valid/req_ready): one transfer carries an operation,
//   a position and a value. Result channel (rsp_valid/rsp_ready): every request
//   gives exactly one result with value, found position, status and the entry
//   count after the operation.
//   A request is taken only in S_IDLE and executed in S_EXEC, where its result
//   is registered; no new request is taken until that has finished. The whole
//   list sits in one RAM row; the transfer edge reads the row, the execute
//   cycle shifts, searches and writes it back, and the idle cycle after it
//   keeps the next read behind that write; the single row port sets the rate.
//   The result register is separate from the request side: a new request is
//   taken while a result waits. If the receiver stalls, the engine holds the
//   next operation in its execute cycle until the result register frees.
//   Reset: synchronous, active high; the list is empty afterwards. Slots
//   beyond the entry count are never observed, so the RAM needs no clearing.
module array_list_engine (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [2:0]                req_operation,
   input  logic [2:0]                req_position,
   input  logic signed [31:0]        req_item_value,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [31:0]        rsp_result_value,
   output logic [2:0]                rsp_found_position,
   output logic [2:0]                rsp_status,
   output logic [3:0]                rsp_entry_count
);

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   localparam int DEPTH  = ale_pkg::DEPTH;
   localparam int DATA_W = ale_pkg::DATA_W;
   localparam int IDX_W  = ale_pkg::IDX_W;
   localparam int CNT_W  = ale_pkg::CNT_W;
   localparam int ROW_W  = ale_pkg::ROW_W;

   state_type                 state_ff;
   ale_pkg::op_type           op_ff;
   logic [IDX_W-1:0]          pos_ff;
   logic [DATA_W-1:0]         val_ff;
   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;

   logic                      rsp_valid_ff;
   logic [DATA_W-1:0]         rsp_value_ff;
   logic [IDX_W-1:0]          rsp_found_ff;
   ale_pkg::status_type       rsp_status_ff;
   logic [CNT_W-1:0]          rsp_count_ff;

   logic [DATA_W-1:0]         res_in;
   logic [IDX_W-1:0]          found_in;
   ale_pkg::status_type       status_in;

   logic [ROW_W-1:0]          rd_row;
   logic [ROW_W-1:0]          wr_row;
   logic                      wr_en;
   logic                      rd_en;
   logic                      req_xfer;
   logic                      finish;

   logic [DATA_W-1:0]         cur  [DEPTH];
   logic [DATA_W-1:0]         nxt  [DEPTH];

   assign req_ready = (state_ff == S_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign rd_en     = req_xfer;
   assign finish    = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign wr_en     = finish;

   ale_ram #(
      .WIDTH (ROW_W),
      .DEPTH (1)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (1'b0),
      .wr_data (wr_row),
      .rd_en   (rd_en),
      .rd_addr (1'b0),
      .rd_data (rd_row)
   );

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         cur[i] = rd_row[i*DATA_W +: DATA_W];
      end
   end

   always_comb begin
      logic [CNT_W-1:0] pos_ext;
      logic [IDX_W-1:0] take;
      logic             full;
      logic             empty;
      logic             hit;
      pos_ext   = {1'b0, pos_ff};
      full      = (count_ff == CNT_W'(DEPTH));
      empty     = (count_ff == '0);
      take      = '0;
      hit       = 1'b0;
      count_in  = count_ff;
      res_in    = '0;
      found_in  = '0;
      status_in = ale_pkg::ST_OK;
      for (int i = 0; i < DEPTH; i++) begin
         nxt[i] = cur[i];
      end
      unique case (op_ff)
         ale_pkg::OP_CLEAR: begin
            count_in = '0;
         end
         ale_pkg::OP_PUSH: begin
            if (full) begin
               status_in = ale_pkg::ST_FULL;
            end else begin
               nxt[count_ff[IDX_W-1:0]] = val_ff;
               count_in = count_ff + 1'b1;
            end
         end
         ale_pkg::OP_INSERT: begin
            if (full) begin
               status_in = ale_pkg::ST_FULL;
            end else if (pos_ext > count_ff) begin
               status_in = ale_pkg::ST_BADIDX;
            end else begin
               for (int i = 1; i < DEPTH; i++) begin
                  if (IDX_W'(i) > pos_ff) begin
                     nxt[i] = cur[i-1];
                  end
               end
               nxt[pos_ff] = val_ff;
               count_in = count_ff + 1'b1;
            end
         end
         ale_pkg::OP_POP_HEAD, ale_pkg::OP_POP_TAIL, ale_pkg::OP_POP_AT: begin
            if (op_ff == ale_pkg::OP_POP_HEAD) begin
               take = '0;
            end else if (op_ff == ale_pkg::OP_POP_TAIL) begin
               take = IDX_W'(count_ff - 1'b1);
            end else begin
               take = pos_ff;
            end
            if (empty) begin
               status_in = ale_pkg::ST_EMPTY;
            end else if (op_ff == ale_pkg::OP_POP_AT && pos_ext >= count_ff) begin
               status_in = ale_pkg::ST_BADIDX;
            end else begin
               res_in = cur[take];
               for (int i = 0; i < DEPTH - 1; i++) begin
                  if (IDX_W'(i) >= take) begin
                     nxt[i] = cur[i+1];
                  end
               end
               count_in = count_ff - 1'b1;
            end
         end
         ale_pkg::OP_READ_AT: begin
            if (empty) begin
               status_in = ale_pkg::ST_EMPTY;
            end else if (pos_ext >= count_ff) begin
               status_in = ale_pkg::ST_BADIDX;
            end else begin
               res_in = cur[pos_ff];
            end
         end
         ale_pkg::OP_FIND: begin
            for (int i = DEPTH - 1; i >= 0; i--) begin
               if ((CNT_W'(i) < count_ff) && (cur[i] == val_ff)) begin
                  hit      = 1'b1;
                  found_in = IDX_W'(i);
               end
            end
            if (!hit) begin
               status_in = ale_pkg::ST_NOTFOUND;
            end
         end
         default: begin
            status_in = ale_pkg::ST_OK;
         end
      endcase
   end

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         wr_row[i*DATA_W +: DATA_W] = nxt[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_xfer) begin
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               if (finish) begin
                  state_ff <= S_IDLE;
                  count_ff <= count_in;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_xfer) begin
         op_ff  <= ale_pkg::op_type'(req_operation);
         pos_ff <= req_position;
         val_ff <= req_item_value;
      end
      if (finish) begin
         rsp_value_ff  <= res_in;
         rsp_found_ff  <= found_in;
         rsp_status_ff <= status_in;
         rsp_count_ff  <= count_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_value   = rsp_value_ff;
   assign rsp_found_position = rsp_found_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_entry_count    = rsp_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above capacity");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == S_EXEC))
      else $error("transfer did not enter execute");

   a_write_in_exec: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_EXEC))
      else $error("row written outside execute");

   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_EXEC))
      else $error("result raised without an execute cycle");

   a_count_change: assert property (@(posedge clock) disable iff (reset)
      !$stable(count_ff) |-> $past(finish))
      else $error("entry count changed without a finished operation");

endmodule

FILE: sim/ale_list_checker.sv
// Watches the request and result channels of array_list_engine, keeps its own copy of the
// list, predicts every result and compares it with what the engine returns.
// Depends on ale_pkg.
module ale_list_checker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic [2:0]               req_operation,
   input  logic [2:0]               req_position,
   input  logic signed [31:0]       req_item_value,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic signed [31:0]       rsp_result_value,
   input  logic [2:0]               rsp_found_position,
   input  logic [2:0]               rsp_status,
   input  logic [3:0]               rsp_entry_count,
   output int                       mismatch_count,
   output int                       outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH  = ale_pkg::DEPTH;
   localparam int DATA_W = ale_pkg::DATA_W;
   localparam int IDX_W  = ale_pkg::IDX_W;
   localparam int CNT_W  = ale_pkg::CNT_W;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic [IDX_W-1:0]         found;
      ale_pkg::status_type      status;
      logic [CNT_W-1:0]         entry_count;
   } list_result_type;

   logic signed [DATA_W-1:0] list_store [DEPTH];
   int                       list_len;
   list_result_type          awaited_results [$];

   function automatic list_result_type apply_list_op(input ale_pkg::op_type op,
                                                     input logic [IDX_W-1:0] pos,
                                                     input logic signed [DATA_W-1:0] val);
      list_result_type r;
      int              i;
      int              slot;
      r.value  = '0;
      r.found  = '0;
      r.status = ale_pkg::ST_OK;
      case (op)
         ale_pkg::OP_CLEAR: begin
            for (i = 0; i < DEPTH; i++) list_store[i] = '0;
            list_len = 0;
         end
         ale_pkg::OP_PUSH: begin
            if (list_len >= DEPTH) begin
               r.status = ale_pkg::ST_FULL;
            end else begin
               list_store[list_len] = val;
               list_len++;
            end
         end
         ale_pkg::OP_INSERT: begin
            if (list_len >= DEPTH) begin
               r.status = ale_pkg::ST_FULL;
            end else if (int'(pos) > list_len) begin
               r.status = ale_pkg::ST_BADIDX;
            end else begin
               for (i = list_len; i > int'(pos); i--) list_store[i] = list_store[i-1];
               list_store[pos] = val;
               list_len++;
            end
         end
         ale_pkg::OP_POP_HEAD, ale_pkg::OP_POP_TAIL, ale_pkg::OP_POP_AT: begin
            if (list_len == 0) begin
               r.status = ale_pkg::ST_EMPTY;
            end else if (op == ale_pkg::OP_POP_AT && int'(pos) >= list_len) begin
               r.status = ale_pkg::ST_BADIDX;
            end else begin
               if (op == ale_pkg::OP_POP_HEAD) slot = 0;
               else if (op == ale_pkg::OP_POP_TAIL) slot = list_len - 1;
               else slot = int'(pos);
               r.value = list_store[slot];
               for (i = slot; i < list_len - 1; i++) list_store[i] = list_store[i+1];
               list_store[list_len-1] = '0;
               list_len--;
            end
         end
         ale_pkg::OP_READ_AT: begin
            if (list_len == 0) r.status = ale_pkg::ST_EMPTY;
            else if (int'(pos) >= list_len) r.status = ale_pkg::ST_BADIDX;
            else r.value = list_store[pos];
         end
         default: begin
            r.status = ale_pkg::ST_NOTFOUND;
            for (i = 0; i < list_len; i++) begin
               if (r.status == ale_pkg::ST_NOTFOUND && list_store[i] == val) begin
                  r.found  = IDX_W'(i);
                  r.status = ale_pkg::ST_OK;
               end
            end
         end
      endcase
      r.entry_count = CNT_W'(list_len);
      return r;
   endfunction

   always @(posedge clock) begin
      list_result_type got;
      list_result_type want;
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) list_store[i] = '0;
         list_len = 0;
         awaited_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.value       = rsp_result_value;
            got.found       = rsp_found_position;
            got.status      = ale_pkg::status_type'(rsp_status);
            got.entry_count = rsp_entry_count;
            if (awaited_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result: value %h pos %0d status %0d count %0d",
                           got.value, got.found, got.status, got.entry_count);
            end else begin
               want = awaited_results.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $write("result mismatch: exp value %h pos %0d status %0d count %0d",
                            want.value, want.found, want.status, want.entry_count);
                     $display(", got value %h pos %0d status %0d count %0d",
                              got.value, got.found, got.status, got.entry_count);
                  end
               end
            end
         end
         if (req_valid && req_ready)
            awaited_results.push_back(apply_list_op(ale_pkg::op_type'(req_operation),
                                                    req_position, req_item_value));
      end
      outstanding = awaited_results.size();
   end

endmodule

FILE: sim/tb_array_list_engine.sv
// Testbench top for array_list_engine: clock, reset, request and result stimulus with
// idling phases, and the final verdict. Depends on ale_pkg, array_list_engine, ale_list_checker.
module tb_array_list_engine;
   timeunit 1ns;
   timeprecision 1ps;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [2:0]         req_operation;
   logic [2:0]         req_position;
   logic signed [31:0] req_item_value;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [31:0] rsp_result_value;
   logic [2:0]         rsp_found_position;
   logic [2:0]         rsp_status;
   logic [3:0]         rsp_entry_count;
   int                 mismatch_count;
   int                 outstanding;

   int                 send_idle_pct;
   int                 recv_stall_pct;
   logic               hold_request;
   logic               long_stall_done;

   array_list_engine u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_position       (req_position),
      .req_item_value     (req_item_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result_value   (rsp_result_value),
      .rsp_found_position (rsp_found_position),
      .rsp_status         (rsp_status),
      .rsp_entry_count    (rsp_entry_count)
   );

   ale_list_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_position       (req_position),
      .req_item_value     (req_item_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result_value   (rsp_result_value),
      .rsp_found_position (rsp_found_position),
      .rsp_status         (rsp_status),
      .rsp_entry_count    (rsp_entry_count),
      .mismatch_count     (mismatch_count),
      .outstanding        (outstanding)
   );

   always #10 clock = ~clock;

   initial begin
      #4_000_000;
      $display("array_list_engine verification failed");
      $finish;
   end

   // receiver: random stalls, plus a long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      long_stall_done = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !long_stall_done) begin
            long_stall_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (200) @(negedge clock);
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   task automatic send_item(input ale_pkg::op_type op, input logic [2:0] pos,
                            input logic signed [31:0] val);
      int gap;
      gap = 0;
      while (gap < 16 && $urandom_range(0, 99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_position   <= pos;
      req_item_value <= val;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
   endtask

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'sh0;
         1: return -32'sd1;
         2: return 32'sh7fffffff;
         3: return 32'sh80000000;
         4, 5: return $urandom_range(0, 7);
         default: return $urandom;
      endcase
   endfunction

   task automatic run_random(input int n_items);
      int              k;
      int              r;
      logic            filling;
      ale_pkg::op_type op;
      filling = 1'b1;
      for (k = 0; k < n_items; k++) begin
         if (k % 16 == 0) filling = 1'($urandom_range(0, 1));
         r = $urandom_range(0, 99);
         if (filling) begin
            if (r < 3) op = ale_pkg::OP_CLEAR;
            else if (r < 33) op = ale_pkg::OP_PUSH;
            else if (r < 58) op = ale_pkg::OP_INSERT;
            else if (r < 63) op = ale_pkg::OP_POP_HEAD;
            else if (r < 68) op = ale_pkg::OP_POP_TAIL;
            else if (r < 75) op = ale_pkg::OP_POP_AT;
            else if (r < 87) op = ale_pkg::OP_READ_AT;
            else op = ale_pkg::OP_FIND;
         end else begin
            if (r < 3) op = ale_pkg::OP_CLEAR;
            else if (r < 13) op = ale_pkg::OP_PUSH;
            else if (r < 20) op = ale_pkg::OP_INSERT;
            else if (r < 38) op = ale_pkg::OP_POP_HEAD;
            else if (r < 56) op = ale_pkg::OP_POP_TAIL;
            else if (r < 74) op = ale_pkg::OP_POP_AT;
            else if (r < 87) op = ale_pkg::OP_READ_AT;
            else op = ale_pkg::OP_FIND;
         end
         send_item(op, 3'($urandom_range(0, 7)), pick_value());
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_operation  = ale_pkg::OP_CLEAR;
      req_position   = '0;
      req_item_value = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_request   = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty list
      send_item(ale_pkg::OP_POP_HEAD, 3'd0, 32'sd0);
      send_item(ale_pkg::OP_POP_TAIL, 3'd0, 32'sd0);
      send_item(ale_pkg::OP_POP_AT,   3'd0, 32'sd0);
      send_item(ale_pkg::OP_READ_AT,  3'd0, 32'sd0);
      send_item(ale_pkg::OP_FIND,     3'd0, 32'sd0);
      // extremes, insert at front, at the end and beyond
      send_item(ale_pkg::OP_PUSH,     3'd0, 32'sh80000000);
      send_item(ale_pkg::OP_PUSH,     3'd7, 32'sh7fffffff);
      send_item(ale_pkg::OP_INSERT,   3'd0, 32'sd0);
      send_item(ale_pkg::OP_INSERT,   3'd3, -32'sd1);
      send_item(ale_pkg::OP_INSERT,   3'd5, 32'sd9);
      send_item(ale_pkg::OP_READ_AT,  3'd3, 32'sd0);
      send_item(ale_pkg::OP_READ_AT,  3'd4, 32'sd0);
      send_item(ale_pkg::OP_FIND,     3'd5, 32'sd0);
      send_item(ale_pkg::OP_FIND,     3'd0, 32'sd12345);
      send_item(ale_pkg::OP_POP_AT,   3'd1, 32'sd0);
      send_item(ale_pkg::OP_POP_AT,   3'd3, 32'sd0);
      // fill up, then hit full
      for (int i = 0; i < 5; i++) send_item(ale_pkg::OP_PUSH, 3'(i), 32'(i + 100));
      send_item(ale_pkg::OP_PUSH,     3'd0, 32'sd1);
      send_item(ale_pkg::OP_INSERT,   3'd7, 32'sd1);
      send_item(ale_pkg::OP_READ_AT,  3'd7, 32'sd0);
      send_item(ale_pkg::OP_FIND,     3'd0, 32'sd104);
      send_item(ale_pkg::OP_POP_TAIL, 3'd0, 32'sd0);
      send_item(ale_pkg::OP_POP_HEAD, 3'd0, 32'sd0);
      send_item(ale_pkg::OP_CLEAR,    3'd0, 32'sd0);
      wait_drain();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
            default: begin send_idle_pct = 31; recv_stall_pct = 31; end
         endcase
         if (phase == 0) begin
            hold_request = 1'b1;
            run_random(12);
         end
         run_random(100);
         wait_drain();
      end

      repeat (10) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("array_list_engine verification clean");
      end else begin
         $display("array_list_engine verification failed");
      end
      $finish;
   end

endmodule
